### hw/rtl/tco_pkg.sv
// Shared types, constants and helper functions for the ternary crazy operation pipeline.
package tco_pkg;

    localparam int unsigned WORD_W = 16;

    typedef logic [1:0]        t_trit;
    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word acc;
    } t_stage_data;

    localparam t_trit TRIT_0 = 2'd0;
    localparam t_trit TRIT_1 = 2'd1;
    localparam t_trit TRIT_2 = 2'd2;

    // Reciprocal constant ceil(2^17 / 3); exact quotient for every 16-bit dividend.
    localparam logic [32:0] DIV3_RECIP = 33'd43691;
    localparam int unsigned DIV3_SHIFT = 17;

    function automatic t_word div3(input t_word x);
        logic [32:0] prod;
        prod = {17'b0, x} * DIV3_RECIP;
        return prod[DIV3_SHIFT +: WORD_W];
    endfunction

    function automatic logic [31:0] pow3_word(input int unsigned n);
        logic [31:0] p;
        p = 32'd1;
        for (int unsigned k = 0; k < n; k++) begin
            p = p * 32'd3;
        end
        return p;
    endfunction

    // Row is the trit of operand b, column the trit of operand a.
    function automatic t_trit crazy_trit(input t_trit tb, input t_trit ta);
        t_trit r;
        case ({tb, ta})
            {TRIT_0, TRIT_0}: r = TRIT_1;
            {TRIT_0, TRIT_1}: r = TRIT_0;
            {TRIT_0, TRIT_2}: r = TRIT_0;
            {TRIT_1, TRIT_0}: r = TRIT_1;
            {TRIT_1, TRIT_1}: r = TRIT_0;
            {TRIT_1, TRIT_2}: r = TRIT_2;
            {TRIT_2, TRIT_0}: r = TRIT_2;
            {TRIT_2, TRIT_1}: r = TRIT_2;
            {TRIT_2, TRIT_2}: r = TRIT_1;
            default:          r = TRIT_0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/ternary_crazy_op.sv
// Top level of the pipelined ternary crazy operation on two words of TRIT_COUNT trits.
//
// A request carries two operands, each the binary value of a ternary word. The
// block combines the low TRIT_COUNT trits of both operands trit by trit through
// the fixed crazy table and returns the ternary result in binary, cut to 16 bits.
//
// Input channel: i_valid with i_operand_a and i_operand_b; the block drives
// o_stall. Output channel: o_valid with o_crazy_result; the receiver drives
// i_stall. A request moves at a rising edge where valid is high and stall low.
//
// The pipeline has one register stage per trit. Each stage divides both operands
// by three with a reciprocal multiply, and a new request can enter every cycle
// while o_stall is low.
//
// When the receiver stalls, the stages fill up behind the output register and
// o_stall rises only once every stage holds a request. Synchronous reset
// empties all stages; no request is in flight afterwards.
module ternary_crazy_op
    import tco_pkg::*;
#(
    parameter int unsigned TRIT_COUNT = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_crazy_result
);

    localparam logic [31:0] RANGE_FULL = pow3_word(TRIT_COUNT) - 32'd1;
    localparam logic [31:0] RESULT_MAX = (RANGE_FULL > 32'd65535) ? 32'd65535 : RANGE_FULL;

    t_stage_data w_data  [0:TRIT_COUNT];
    logic        w_valid [0:TRIT_COUNT];
    logic        w_stall [0:TRIT_COUNT];

    assign w_data[0].a   = i_operand_a;
    assign w_data[0].b   = i_operand_b;
    assign w_data[0].acc = '0;
    assign w_valid[0]    = i_valid;
    assign o_stall       = w_stall[0];

    for (genvar k = 0; k < TRIT_COUNT; k++) begin : g_stage
        tco_trit_stage #(
            .TRIT_POS(k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_data  (w_data[k]),
            .o_stall (w_stall[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_data[k+1]),
            .i_stall (w_stall[k+1])
        );
    end

    assign w_stall[TRIT_COUNT] = i_stall;
    assign o_valid             = w_valid[TRIT_COUNT];
    assign o_crazy_result      = w_data[TRIT_COUNT].acc;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("Input stalled while the output stage could still move.");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({16'b0, o_crazy_result} <= RESULT_MAX))
        else $error("Result exceeds the ternary word range.");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid right after reset.");
`endif

endmodule

### hw/rtl/tco_trit_stage.sv
// One pipeline stage that peels off one trit of each operand and adds its result trit.
module tco_trit_stage
    import tco_pkg::*;
#(
    parameter int unsigned TRIT_POS = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_stage_data i_data,
    output logic        o_stall,
    output logic        o_valid,
    output t_stage_data o_data,
    input  logic        i_stall
);

    localparam logic [31:0] PLACE_FULL  = pow3_word(TRIT_POS);
    localparam logic [31:0] PLACE2_FULL = PLACE_FULL << 1;
    localparam t_word       PLACE       = PLACE_FULL[WORD_W-1:0];
    localparam t_word       PLACE2      = PLACE2_FULL[WORD_W-1:0];

    logic        r_valid;
    t_stage_data r_data;
    t_stage_data n_data;
    logic        w_load;
    t_word       w_qa;
    t_word       w_qb;
    t_word       w_ra;
    t_word       w_rb;
    t_trit       w_trit;
    t_word       w_add;

    always_comb begin
        w_qa   = div3(i_data.a);
        w_qb   = div3(i_data.b);
        w_ra   = i_data.a - {w_qa[WORD_W-2:0], 1'b0} - w_qa;
        w_rb   = i_data.b - {w_qb[WORD_W-2:0], 1'b0} - w_qb;
        w_trit = crazy_trit(w_rb[1:0], w_ra[1:0]);
        case (w_trit)
            TRIT_1:  w_add = PLACE;
            TRIT_2:  w_add = PLACE2;
            default: w_add = '0;
        endcase
        n_data.a   = w_qa;
        n_data.b   = w_qb;
        n_data.acc = i_data.acc + w_add;
    end

    assign w_load  = !r_valid || !i_stall;
    assign o_stall = !w_load;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
